// ===== rtl/core/bdqs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque with search: shared definitions
// Request codes, field widths and the default depth of the store.
// ----------------------------------------------------------------------------
package bdqs_pkg;

    localparam int REQ_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DROP_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DROP_BACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

    // Port controls from the sequencer to the slot memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/bounded_deque_with_search_top.sv =====
`default_nettype none
// Push and drop requests register their result strobe after the operation state;
// a search first fetches the front entry, then scans k entries, k being at most
// the count (so up to DEPTH). The scan reads one slot per cycle through the
// single read port of the slot memory.
// A new request is accepted in the strobe cycle; the receiver cannot stall.
// Reset clears head, count and control at once; slot contents stay undefined.
// ----------------------------------------------------------------------------
// Deque with search: top level
// Bounded double-ended queue of signed values with a front-to-back search.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire [bdqs_pkg::REQ_W-1:0]          req_type,
    input  wire signed [bdqs_pkg::VALUE_W-1:0] item_value,
    output logic                               done,
    output logic                               ok,
    output logic [bdqs_pkg::COUNT_W-1:0]       entry_count
);
    import bdqs_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   mem_addr;
    logic [VALUE_W-1:0] mem_wr_data;
    logic [VALUE_W-1:0] mem_rd_data;

    bdqs_ctrl #(
        .DEPTH(DEPTH),
        .IDX_W(IDX_W),
        .CNT_W(CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .item_value (item_value),
        .busy       (busy),
        .done       (done),
        .ok         (ok),
        .entry_count(entry_count),
        .mem_ctl    (mem_ctl),
        .mem_addr   (mem_addr),
        .mem_wr_data(mem_wr_data),
        .mem_rd_data(mem_rd_data)
    );

    bdqs_store #(
        .DEPTH(DEPTH),
        .IDX_W(IDX_W)
    ) u_store (
        .clk    (clk),
        .ctl    (mem_ctl),
        .addr   (mem_addr),
        .wr_data(mem_wr_data),
        .rd_data(mem_rd_data)
    );

    // Every request gives exactly one strobe, never two in a row.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while a request is in progress");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start work");

    a_memory_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("slot memory written and read in the same cycle");

endmodule
`default_nettype wire

// ===== rtl/core/bdqs_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque with search: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdqs_store #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                              clk,
    input  wire bdqs_pkg::mem_ctl_t          ctl,
    input  wire [IDX_W-1:0]                  addr,
    input  wire [bdqs_pkg::VALUE_W-1:0]      wr_data,
    output logic [bdqs_pkg::VALUE_W-1:0]     rd_data
);
    import bdqs_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bdqs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque with search: sequencer
// Holds the head and count, and drives one shared ring-position adder and
// one value comparator over the steps of each request.
// ----------------------------------------------------------------------------
module bdqs_ctrl #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire [bdqs_pkg::REQ_W-1:0]        req_type,
    input  wire signed [bdqs_pkg::VALUE_W-1:0] item_value,
    output logic                             busy,
    output logic                             done,
    output logic                             ok,
    output logic [bdqs_pkg::COUNT_W-1:0]     entry_count,
    output bdqs_pkg::mem_ctl_t               mem_ctl,
    output logic [IDX_W-1:0]                 mem_addr,
    output logic [bdqs_pkg::VALUE_W-1:0]     mem_wr_data,
    input  wire [bdqs_pkg::VALUE_W-1:0]      mem_rd_data
);
    import bdqs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_OP   = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    localparam logic [IDX_W:0] DEPTH_S = (IDX_W + 1)'(DEPTH);

    logic [1:0]         state_reg, state_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               ok_reg, ok_next;
    logic               done_reg, done_next;

    logic [IDX_W-1:0]   offset;
    logic [IDX_W:0]     pos_sum;
    logic [IDX_W-1:0]   ring_pos;
    logic               full;
    logic               empty;
    logic               hit;
    logic               last_entry;

    // Shared ring-position unit: head plus an offset, wrapped once.
    always_comb
    begin
        pos_sum  = {1'b0, head_reg} + {1'b0, offset};
        ring_pos = (pos_sum >= DEPTH_S) ? IDX_W'(pos_sum - DEPTH_S) : IDX_W'(pos_sum);
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign hit        = (mem_rd_data == val_reg);
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        val_next   = val_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ok_next    = ok_reg;
        done_next  = 1'b0;
        offset     = '0;
        mem_ctl    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    val_next   = item_value;
                    state_next = ST_OP;
                end
            end
            ST_OP:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                ok_next    = 1'b0;
                unique case (req_reg)
                    REQ_PUSH_FRONT:
                    begin
                        offset = IDX_W'(DEPTH - 1);
                        if (!full)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            head_next     = ring_pos;
                            count_next    = count_reg + CNT_W'(1);
                            ok_next       = 1'b1;
                        end
                    end
                    REQ_PUSH_BACK:
                    begin
                        offset = IDX_W'(count_reg);
                        if (!full)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            ok_next       = 1'b1;
                        end
                    end
                    REQ_DROP_FRONT:
                    begin
                        offset = IDX_W'(1);
                        if (!empty)
                        begin
                            head_next  = ring_pos;
                            count_next = count_reg - CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    REQ_DROP_BACK:
                    begin
                        if (!empty)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (!empty)
                        begin
                            // Fetch the front entry; the scan compares it next cycle.
                            mem_ctl.rd_en = 1'b1;
                            idx_next      = '0;
                            done_next     = 1'b0;
                            state_next    = ST_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (hit || last_entry)
                begin
                    ok_next    = hit;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    offset        = idx_reg + IDX_W'(1);
                    mem_ctl.rd_en = 1'b1;
                    idx_next      = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            ok_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        val_reg <= val_next;
        idx_reg <= idx_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign entry_count = COUNT_W'(count_reg);
    assign mem_addr    = ring_pos;
    assign mem_wr_data = val_reg;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Deque with search: testbench
// Sends push, drop and search requests through the start/busy handshake:
// first a short table of requests, then random traffic that swings the store
// between empty and full. A model of the store inside the bench predicts
// each reply, and every done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import bdqs_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    // Request codes that the block leaves unused.
    localparam logic [REQ_W-1:0] REQ_UNUSED_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 250;
    localparam int TREND_SPAN       = 60;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } reply_t;

    typedef struct {
        logic [REQ_W-1:0]          req;
        logic signed [VALUE_W-1:0] val;
        int                        reps;
        bit                        typed;
        logic                      exp_ok;
        logic [COUNT_W-1:0]        exp_count;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] item_value;
    logic                      done;
    logic                      ok;
    logic [COUNT_W-1:0]        entry_count;

    // Bench copy of the store.
    logic signed [VALUE_W-1:0] deque_slots [DEPTH];
    int                        deque_head;
    int                        deque_count;

    reply_t pending_replies [$];
    int     error_count;
    int     sender_idle_pct;
    int     push_bias_pct;

    // A repeated row adds its repeat index to the value.
    stim_row_t directed_rows [23] = '{
        '{REQ_DROP_FRONT, 32'sh0000_0000,  1, 1'b1, 1'b0, 5'd0},
        '{REQ_DROP_BACK,  32'sh0000_0000,  1, 1'b1, 1'b0, 5'd0},
        '{REQ_SEARCH,     32'sh0000_0000,  1, 1'b1, 1'b0, 5'd0},
        '{REQ_UNUSED_5,   32'sh1234_5678,  1, 1'b1, 1'b0, 5'd0},
        '{REQ_UNUSED_7,   32'shFFFF_FFFF,  1, 1'b1, 1'b0, 5'd0},
        '{REQ_PUSH_BACK,  32'sh7FFF_FFFF,  1, 1'b1, 1'b1, 5'd1},
        '{REQ_PUSH_FRONT, 32'sh8000_0000,  1, 1'b1, 1'b1, 5'd2},
        '{REQ_SEARCH,     32'sh8000_0000,  1, 1'b1, 1'b1, 5'd2},
        '{REQ_SEARCH,     32'sh7FFF_FFFF,  1, 1'b1, 1'b1, 5'd2},
        '{REQ_SEARCH,     32'sh0000_0000,  1, 1'b1, 1'b0, 5'd2},
        '{REQ_DROP_BACK,  32'sh0000_0000,  1, 1'b1, 1'b1, 5'd1},
        '{REQ_SEARCH,     32'sh7FFF_FFFF,  1, 1'b1, 1'b0, 5'd1},
        '{REQ_DROP_BACK,  32'sh0000_0000,  1, 1'b1, 1'b1, 5'd0},
        '{REQ_PUSH_FRONT, 32'sh0000_0001, 16, 1'b0, 1'b0, 5'd0},
        '{REQ_PUSH_BACK,  32'sh0000_0005,  1, 1'b1, 1'b0, 5'd16},
        '{REQ_PUSH_FRONT, 32'sh0000_0005,  1, 1'b1, 1'b0, 5'd16},
        '{REQ_SEARCH,     32'sh0000_0001,  1, 1'b0, 1'b0, 5'd0},
        '{REQ_SEARCH,     32'sh5555_5555,  1, 1'b0, 1'b0, 5'd0},
        '{REQ_DROP_FRONT, 32'sh0000_0000,  8, 1'b0, 1'b0, 5'd0},
        '{REQ_DROP_BACK,  32'sh0000_0000,  8, 1'b0, 1'b0, 5'd0},
        '{REQ_UNUSED_6,   32'sh0000_0000,  1, 1'b1, 1'b0, 5'd0},
        '{REQ_PUSH_BACK,  32'shAAAA_AAAA,  1, 1'b0, 1'b0, 5'd0},
        '{REQ_PUSH_BACK,  32'sh5555_5555,  1, 1'b0, 1'b0, 5'd0}
    };

    bounded_deque_with_search_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .item_value (item_value),
        .done       (done),
        .ok         (ok),
        .entry_count(entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one request to the bench copy of the store and returns the reply.
    function automatic reply_t apply_request(input logic [REQ_W-1:0] req,
                                             input logic signed [VALUE_W-1:0] val);
        reply_t r;
        r.ok = 1'b0;
        case (req)
            REQ_PUSH_FRONT:
            begin
                if (deque_count < DEPTH)
                begin
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    deque_slots[deque_head] = val;
                    deque_count++;
                    r.ok = 1'b1;
                end
            end
            REQ_PUSH_BACK:
            begin
                if (deque_count < DEPTH)
                begin
                    deque_slots[(deque_head + deque_count) % DEPTH] = val;
                    deque_count++;
                    r.ok = 1'b1;
                end
            end
            REQ_DROP_FRONT:
            begin
                if (deque_count > 0)
                begin
                    deque_head = (deque_head + 1) % DEPTH;
                    deque_count--;
                    r.ok = 1'b1;
                end
            end
            REQ_DROP_BACK:
            begin
                if (deque_count > 0)
                begin
                    deque_count--;
                    r.ok = 1'b1;
                end
            end
            REQ_SEARCH:
            begin
                for (int i = 0; i < deque_count; i++)
                begin
                    if (deque_slots[(deque_head + i) % DEPTH] == val)
                        r.ok = 1'b1;
                end
            end
            default:
            begin
                r.ok = 1'b0;
            end
        endcase
        r.count = COUNT_W'(deque_count);
        return r;
    endfunction

    // Called right after a falling edge; returns right after the falling edge
    // that follows acceptance.
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic signed [VALUE_W-1:0] val,
                                input bit typed,
                                input logic exp_ok,
                                input logic [COUNT_W-1:0] exp_count);
        reply_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        req_type   <= req;
        item_value <= val;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_request(req, val);
        if (typed)
        begin
            predicted.ok    = exp_ok;
            predicted.count = exp_count;
        end
        pending_replies.push_back(predicted);
        @(negedge clk);
    endtask

    // Random request. The push/drop balance follows push_bias_pct so that the
    // store drifts between empty and full.
    task automatic pick_request(output logic [REQ_W-1:0] req,
                                output logic signed [VALUE_W-1:0] val);
        int roll;
        int pick;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        val  = $urandom;
        if (roll < 3)
        begin
            req = REQ_W'($urandom_range(REQ_UNUSED_5, REQ_UNUSED_7));
        end
        else if (roll < 30)
        begin
            req = REQ_SEARCH;
            if (pick < 55 && deque_count > 0)
                val = deque_slots[(deque_head + $urandom_range(deque_count - 1)) % DEPTH];
            else if (pick < 70)
                val = $signed($urandom_range(7)) - 4;
        end
        else if ($urandom_range(99) < push_bias_pct)
        begin
            req = pick[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            // A small pool of values makes duplicates in the store likely.
            if (pick < 25)
                val = $signed($urandom_range(7)) - 4;
        end
        else
        begin
            req = pick[0] ? REQ_DROP_FRONT : REQ_DROP_BACK;
        end
    endtask

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with no request pending: ok=%0d count=%0d",
                         $time, ok, entry_count);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (ok !== want.ok)
                begin
                    $display("%0t: ok mismatch: expected %0d, actual %0d",
                             $time, want.ok, ok);
                    error_count++;
                end
                if (entry_count !== want.count)
                begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, want.count, entry_count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [REQ_W-1:0]          req;
        logic signed [VALUE_W-1:0] val;
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = REQ_PUSH_FRONT;
        item_value      = '0;
        error_count     = 0;
        deque_head      = 0;
        deque_count     = 0;
        sender_idle_pct = 8;
        push_bias_pct   = 75;
        for (int i = 0; i < DEPTH; i++)
            deque_slots[i] = '0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[n])
        begin
            for (int k = 0; k < directed_rows[n].reps; k++)
            begin
                send_request(directed_rows[n].req, directed_rows[n].val + k,
                             directed_rows[n].typed, directed_rows[n].exp_ok,
                             directed_rows[n].exp_count);
            end
        end

        // Sender idles rarely, then often, then not at all.
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 59 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % TREND_SPAN == 0)
                    push_bias_pct = (push_bias_pct > 50) ? 25 : 75;
                pick_request(req, val);
                send_request(req, val, 1'b0, 1'b0, '0);
            end
        end

        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
